[sv/plam_pkg.sv]
// shared types, codes and helper functions for the packed lane add/sub/mul unit
// no dependencies; imported by every module of the block
package plam_pkg;

	// configuration port geometry: four registers on 8-byte spacing
	localparam int APB_AW = 5;
	localparam int APB_DW = 64;
	localparam int WORDS_CARRIED = 4;

	// register index, taken from paddr[4:3]
	typedef enum logic [1:0] {
		REG_OP_SELECT      = 2'd0,
		REG_LANE_WIDTH     = 2'd1,
		REG_RHS_BROADCAST  = 2'd2,
		REG_SCALAR_OPERAND = 2'd3
	} reg_idx_t;

	// lane operation; the fourth code passes the left operand through
	typedef enum logic [1:0] {
		OP_ADD  = 2'd0,
		OP_SUB  = 2'd1,
		OP_MUL  = 2'd2,
		OP_PASS = 2'd3
	} op_t;

	// lane width code
	typedef enum logic [1:0] {
		LW_8  = 2'd0,
		LW_16 = 2'd1,
		LW_32 = 2'd2,
		LW_64 = 2'd3
	} lw_t;

	// configuration register file contents
	typedef struct packed {
		op_t         op;
		lw_t         lane_width;
		logic        rhs_broadcast;
		logic [63:0] scalar_operand;
	} cfg_t;

	// per-item control carried down the pipeline
	typedef struct packed {
		op_t op;
		lw_t lane_width;
	} ctl_t;

	// input item
	typedef struct packed {
		logic [63:0] a_word0;
		logic [63:0] a_word1;
		logic [63:0] a_word2;
		logic [63:0] a_word3;
		logic [63:0] b_word0;
		logic [63:0] b_word1;
		logic [63:0] b_word2;
		logic [63:0] b_word3;
		logic [5:0]  valid_elements;
	} in_item_t;

	// result item
	typedef struct packed {
		logic [63:0] out_word0;
		logic [63:0] out_word1;
		logic [63:0] out_word2;
		logic [63:0] out_word3;
		logic [5:0]  out_valid_elements;
	} out_item_t;

	// replicate the low lane-width bits of the scalar across a word
	function automatic logic [63:0] splat(input logic [63:0] s, input lw_t lw);
		logic [63:0] r;
		case (lw)
			LW_8:    r = {8{s[7:0]}};
			LW_16:   r = {4{s[15:0]}};
			LW_32:   r = {2{s[31:0]}};
			LW_64:   r = s;
			default: r = s;
		endcase
		return r;
	endfunction

	// byte-sliced add/subtract with the carry cut at every lane boundary
	function automatic logic [63:0] lane_addsub(input logic [63:0] a, input logic [63:0] b,
			input logic sub, input lw_t lw);
		logic [63:0] r;
		logic        c;
		logic [8:0]  s;
		logic [2:0]  m;
		m = 3'((4'd1 << lw) - 4'd1);
		c = sub;
		r = '0;
		for (int i = 0; i < 8; i++) begin
			if ((3'(i) & m) == 3'd0) begin
				c = sub;
			end
			s = {1'b0, a[8*i +: 8]} + {1'b0, b[8*i +: 8] ^ {8{sub}}} + {8'd0, c};
			r[8*i +: 8] = s[7:0];
			c = s[8];
		end
		return r;
	endfunction

endpackage

[sv/plam_apb_regs.sv]
// configuration register file behind an apb-style write/read port
// depends on plam_pkg for register indexes and the cfg_t type
module plam_apb_regs
	import plam_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[4:3]);
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	// register writes on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_OP_SELECT:      cfg_q.op             <= op_t'(pwdata[1:0]);
				REG_LANE_WIDTH:     cfg_q.lane_width     <= lw_t'(pwdata[1:0]);
				REG_RHS_BROADCAST:  cfg_q.rhs_broadcast  <= pwdata[0];
				REG_SCALAR_OPERAND: cfg_q.scalar_operand <= pwdata;
				default:            cfg_q                <= cfg_q;
			endcase
		end
	end

	// read-back mux
	always_comb begin
		case (idx)
			REG_OP_SELECT:      prdata = {62'd0, cfg_q.op};
			REG_LANE_WIDTH:     prdata = {62'd0, cfg_q.lane_width};
			REG_RHS_BROADCAST:  prdata = {63'd0, cfg_q.rhs_broadcast};
			REG_SCALAR_OPERAND: prdata = cfg_q.scalar_operand;
			default:            prdata = '0;
		endcase
	end

endmodule

[sv/plam_word_unit.sv]
// datapath for one 64-bit word: lane products and add/sub, then combine and select
// depends on plam_pkg for ctl_t, op and lane width codes and lane_addsub
module plam_word_unit
	import plam_pkg::*;
(
	input  logic        clk,
	input  logic [63:0] a_s1,
	input  logic [63:0] b_s1,
	input  ctl_t        ctl_s1,
	output logic [63:0] word_s3
);

	// stage 2 registers
	logic [7:0]  p8_s2  [8];
	logic [15:0] p16_s2 [4];
	logic [63:0] lolo_s2;
	logic [31:0] hihi_s2;
	logic [31:0] cross1_s2;
	logic [31:0] cross2_s2;
	logic [63:0] alu_s2;
	ctl_t        ctl_s2;

	logic [63:0] alu_d;
	logic [31:0] hi64;
	logic [63:0] prod;

	// add, subtract or pass-through
	always_comb begin
		case (ctl_s1.op)
			OP_ADD:  alu_d = lane_addsub(a_s1, b_s1, 1'b0, ctl_s1.lane_width);
			OP_SUB:  alu_d = lane_addsub(a_s1, b_s1, 1'b1, ctl_s1.lane_width);
			default: alu_d = a_s1;
		endcase
	end

	// lane multipliers, one register after each
	always_ff @(posedge clk) begin
		for (int i = 0; i < 8; i++) begin
			p8_s2[i] <= a_s1[8*i +: 8] * b_s1[8*i +: 8];
		end
		for (int j = 0; j < 4; j++) begin
			p16_s2[j] <= a_s1[16*j +: 16] * b_s1[16*j +: 16];
		end
		lolo_s2   <= {32'd0, a_s1[31:0]} * {32'd0, b_s1[31:0]};
		hihi_s2   <= a_s1[63:32] * b_s1[63:32];
		cross1_s2 <= a_s1[31:0] * b_s1[63:32];
		cross2_s2 <= a_s1[63:32] * b_s1[31:0];
		alu_s2    <= alu_d;
		ctl_s2    <= ctl_s1;
	end

	// 64-bit product: low partial product plus the cross products shifted up by 32
	assign hi64 = lolo_s2[63:32] + cross1_s2 + cross2_s2;

	// pick the product layout for the lane width
	always_comb begin
		case (ctl_s2.lane_width)
			LW_8:    prod = {p8_s2[7], p8_s2[6], p8_s2[5], p8_s2[4],
					p8_s2[3], p8_s2[2], p8_s2[1], p8_s2[0]};
			LW_16:   prod = {p16_s2[3], p16_s2[2], p16_s2[1], p16_s2[0]};
			LW_32:   prod = {hihi_s2, lolo_s2[31:0]};
			LW_64:   prod = {hi64, lolo_s2[31:0]};
			default: prod = {hi64, lolo_s2[31:0]};
		endcase
	end

	// stage 3 result register
	always_ff @(posedge clk) begin
		if (ctl_s2.op == OP_MUL) begin
			word_s3 <= prod;
		end else begin
			word_s3 <= alu_s2;
		end
	end

endmodule

[sv/packed_lane_add_sub_mul_unit.sv]
// packed lane add/sub/mul unit: the result strobe (done) is the valid bit of the last register
// stage, set for each accepted item; one item per cycle, busy is never high
// three register stages: operand capture, lane multipliers, product combine and select
// the receiver cannot stall, so the pipeline always advances
// reset clears the stage valid bits and all configuration registers to zero
module packed_lane_add_sub_mul_unit
	import plam_pkg::*;
#(
	parameter int VECTOR_BITS = 256
)
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [APB_AW-1:0]         paddr,
	input  logic [APB_DW-1:0]         pwdata,
	output logic [APB_DW-1:0]         prdata,
	output logic                      pready,
	input  logic                      start,
	output logic                      busy,
	input  in_item_t                  operands,
	output logic                      done,
	output out_item_t                 result
);

	localparam int WORDS_FIT  = VECTOR_BITS / 64;
	localparam int WORDS_USED = (WORDS_FIT < WORDS_CARRIED) ? WORDS_FIT : WORDS_CARRIED;

	cfg_t        cfg;
	logic        accept;
	logic [63:0] a_in   [WORDS_CARRIED];
	logic [63:0] b_in   [WORDS_CARRIED];
	logic [63:0] b_splat;
	logic [63:0] a_s1   [WORDS_CARRIED];
	logic [63:0] b_s1   [WORDS_CARRIED];
	logic [63:0] word_s3 [WORDS_CARRIED];
	ctl_t        ctl_s1;
	logic [5:0]  cnt_s1;
	logic [5:0]  cnt_s2;
	logic [5:0]  cnt_s3;
	logic        v_s1;
	logic        v_s2;
	logic        v_s3;

	plam_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// unpack the item words
	assign a_in[0] = operands.a_word0;
	assign a_in[1] = operands.a_word1;
	assign a_in[2] = operands.a_word2;
	assign a_in[3] = operands.a_word3;
	assign b_in[0] = operands.b_word0;
	assign b_in[1] = operands.b_word1;
	assign b_in[2] = operands.b_word2;
	assign b_in[3] = operands.b_word3;

	assign b_splat = splat(cfg.scalar_operand, cfg.lane_width);

	// stage 1: capture operands, right side replaced by the scalar in broadcast mode
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int w = 0; w < WORDS_CARRIED; w++) begin
				a_s1[w] <= a_in[w];
				b_s1[w] <= cfg.rhs_broadcast ? b_splat : b_in[w];
			end
			ctl_s1.op         <= cfg.op;
			ctl_s1.lane_width <= cfg.lane_width;
			cnt_s1            <= operands.valid_elements;
		end
	end

	// lane count travels alongside the data
	always_ff @(posedge clk) begin
		cnt_s2 <= cnt_s1;
		cnt_s3 <= cnt_s2;
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// one word unit per word that fits the vector; the rest read as zero
	for (genvar g = 0; g < WORDS_CARRIED; g++) begin : g_word
		if (g < WORDS_USED) begin : g_used
			plam_word_unit u_word (
				.clk     (clk),
				.a_s1    (a_s1[g]),
				.b_s1    (b_s1[g]),
				.ctl_s1  (ctl_s1),
				.word_s3 (word_s3[g])
			);
		end else begin : g_unused
			assign word_s3[g] = '0;
		end
	end

	// result item
	assign done                      = v_s3;
	assign result.out_word0          = word_s3[0];
	assign result.out_word1          = word_s3[1];
	assign result.out_word2          = word_s3[2];
	assign result.out_word3          = word_s3[3];
	assign result.out_valid_elements = cnt_s3;

endmodule

[sim/packed_lane_add_sub_mul_unit_tb.sv]
// self-checking testbench for the packed lane add/sub/mul unit: directed and random items
// depends on plam_pkg and packed_lane_add_sub_mul_unit; lane results predicted in the bench
module packed_lane_add_sub_mul_unit_tb;
	import plam_pkg::*;

	localparam int VEC_BITS = 256;
	localparam int PIPE_LATENCY = 3;
	localparam int STALL_LIMIT = 1000;
	localparam int RANDOM_ITEMS = 1750;
	localparam int FULL_RATE_ITEMS = 200;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;
	logic              start;
	logic              busy;
	in_item_t          operands;
	logic              done;
	out_item_t         result;

	// bench copy of the configuration registers
	op_t         cur_op;
	lw_t         cur_lw;
	logic        cur_bcast;
	logic [63:0] cur_scalar;

	out_item_t lane_results_due[$];
	int        mismatch_count = 0;
	int        items_sent;
	int        stall_cycles = 0;
	bit        gaps_on;

	packed_lane_add_sub_mul_unit #(.VECTOR_BITS(VEC_BITS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.start(start),
		.busy(busy),
		.operands(operands),
		.done(done),
		.result(result)
	);

	// clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// one lane of the selected operation, wrapped to the lane width
	function automatic logic [63:0] lane_value(input logic [63:0] a, input logic [63:0] b,
			input logic [63:0] mask);
		logic [63:0] r;
		case (cur_op)
			OP_ADD:  r = a + b;
			OP_SUB:  r = a - b;
			// low half of the product; the partial-product split gives the same bits
			OP_MUL:  r = a * b;
			default: r = a;
		endcase
		return r & mask;
	endfunction

	// whole-vector prediction from the bench configuration
	function automatic out_item_t predict_lanes(input in_item_t it);
		logic [63:0] a_w[4];
		logic [63:0] b_w[4];
		logic [63:0] r_w[4];
		logic [63:0] mask;
		logic [63:0] rhs_splat;
		logic [63:0] rhs;
		int          lane_bits;
		int          n_words;
		out_item_t   r;
		lane_bits = 8 << int'(cur_lw);
		mask = (lane_bits == 64) ? '1 : ((64'd1 << lane_bits) - 64'd1);
		n_words = (VEC_BITS / 64 < WORDS_CARRIED) ? VEC_BITS / 64 : WORDS_CARRIED;
		a_w = '{it.a_word0, it.a_word1, it.a_word2, it.a_word3};
		b_w = '{it.b_word0, it.b_word1, it.b_word2, it.b_word3};
		rhs_splat = '0;
		for (int sh = 0; sh < 64; sh += lane_bits) begin
			rhs_splat |= (cur_scalar & mask) << sh;
		end
		for (int w = 0; w < 4; w++) begin
			r_w[w] = '0;
			if (w < n_words) begin
				rhs = cur_bcast ? rhs_splat : b_w[w];
				for (int sh = 0; sh < 64; sh += lane_bits) begin
					r_w[w] |= lane_value((a_w[w] >> sh) & mask, (rhs >> sh) & mask, mask) << sh;
				end
			end
		end
		r.out_word0 = r_w[0];
		r.out_word1 = r_w[1];
		r.out_word2 = r_w[2];
		r.out_word3 = r_w[3];
		r.out_valid_elements = it.valid_elements;
		return r;
	endfunction

	// one line per mismatch, and count it
	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// result checker
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && done) begin
			if (lane_results_due.size() == 0) begin
				report_mismatch("unexpected result", result.out_word0, '0);
			end else begin
				want = lane_results_due.pop_front();
				if (result.out_word0 !== want.out_word0)
					report_mismatch("out_word0", result.out_word0, want.out_word0);
				if (result.out_word1 !== want.out_word1)
					report_mismatch("out_word1", result.out_word1, want.out_word1);
				if (result.out_word2 !== want.out_word2)
					report_mismatch("out_word2", result.out_word2, want.out_word2);
				if (result.out_word3 !== want.out_word3)
					report_mismatch("out_word3", result.out_word3, want.out_word3);
				if (result.out_valid_elements !== want.out_valid_elements)
					report_mismatch("out_valid_elements", 64'(result.out_valid_elements),
						64'(want.out_valid_elements));
			end
		end
	end

	// cycles with no handshake of any kind
	always @(posedge clk) begin
		if ((start && !busy) || done || (psel && penable && pready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// watchdog
	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("packed_lane_add_sub_mul_unit_tb: done, errors");
		$finish;
	end

	// send one item, with an optional idle burst ahead of it
	task automatic send_item(input in_item_t it);
		int gap;
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 7);
			@(negedge clk);
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end else begin
			@(negedge clk);
		end
		start = 1'b1;
		operands = it;
		do @(posedge clk); while (busy);
		lane_results_due.push_back(predict_lanes(it));
		items_sent++;
	endtask

	// stop sending and let every outstanding item come back
	task automatic wait_results_drained();
		@(negedge clk);
		start = 1'b0;
		while (lane_results_due.size() != 0) @(posedge clk);
		repeat (PIPE_LATENCY + 2) @(posedge clk);
	endtask

	// write one register, then read it back
	task automatic write_reg(input reg_idx_t idx, input logic [63:0] val);
		logic [63:0] want;
		case (idx)
			REG_OP_SELECT:     want = {62'd0, val[1:0]};
			REG_LANE_WIDTH:    want = {62'd0, val[1:0]};
			REG_RHS_BROADCAST: want = {63'd0, val[0]};
			default:           want = val;
		endcase
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = APB_AW'({idx, 3'b000});
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_OP_SELECT:     cur_op = op_t'(val[1:0]);
			REG_LANE_WIDTH:    cur_lw = lw_t'(val[1:0]);
			REG_RHS_BROADCAST: cur_bcast = val[0];
			default:           cur_scalar = val;
		endcase
		@(negedge clk);
		penable = 1'b0;
		pwrite = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want) report_mismatch("register readback", prdata, want);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	// full configuration change, only with the pipeline empty
	task automatic set_config(input op_t op, input lw_t lw, input logic bcast,
			input logic [63:0] scalar);
		wait_results_drained();
		write_reg(REG_OP_SELECT, 64'(op));
		write_reg(REG_LANE_WIDTH, 64'(lw));
		write_reg(REG_RHS_BROADCAST, 64'(bcast));
		write_reg(REG_SCALAR_OPERAND, scalar);
	endtask

	// random word, biased towards lane boundary patterns
	function automatic logic [63:0] rand_word();
		case ($urandom_range(0, 9))
			0:       return '1;
			1:       return '0;
			2:       return {8{8'h80}};
			3:       return {8{8'h7f}};
			4:       return {4{16'h8000}};
			5:       return {2{32'h7fffffff}};
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [63:0] rand_scalar();
		case ($urandom_range(0, 5))
			0:       return '1;
			1:       return '0;
			2:       return 64'h8000_0000_0000_0000;
			3:       return 64'($urandom_range(0, 3));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic in_item_t rand_item();
		in_item_t it;
		it.a_word0 = rand_word();
		it.a_word1 = rand_word();
		it.a_word2 = rand_word();
		it.a_word3 = rand_word();
		it.b_word0 = rand_word();
		it.b_word1 = rand_word();
		it.b_word2 = rand_word();
		it.b_word3 = rand_word();
		// mostly legal counts, now and then anything the field holds
		if ($urandom_range(0, 7) == 0) begin
			it.valid_elements = 6'($urandom_range(0, 63));
		end else begin
			it.valid_elements = 6'($urandom_range(1, 32));
		end
		return it;
	endfunction

	// fixed item with carries and borrows across every lane boundary
	function automatic in_item_t edge_item(input logic [5:0] count);
		in_item_t it;
		it.a_word0 = '1;
		it.a_word1 = '0;
		it.a_word2 = 64'h8000_0000_8000_8080;
		it.a_word3 = 64'h7fff_ffff_7fff_7f7f;
		it.b_word0 = 64'd1;
		it.b_word1 = '1;
		it.b_word2 = {8{8'h80}};
		it.b_word3 = {8{8'h01}};
		it.valid_elements = count;
		return it;
	endfunction

	// reset values, then every operation at every lane width
	task automatic test_all_ops();
		send_item(edge_item(6'd32));
		for (int o = 0; o < 4; o++) begin
			for (int l = 0; l < 4; l++) begin
				set_config(op_t'(o), lw_t'(l), 1'((o + l) % 2),
					(l % 2 == 0) ? 64'hffff_ffff_ffff_ffff : 64'h8000_0000_0000_0001);
				send_item(edge_item(6'(1 + o * 4 + l)));
			end
		end
	endtask

	// short final vector and counts outside the legal range
	task automatic test_count_edges();
		logic [5:0] counts[5];
		counts = '{6'd0, 6'd1, 6'd32, 6'd33, 6'd63};
		set_config(OP_MUL, LW_64, 1'b0, '0);
		foreach (counts[i]) send_item(edge_item(counts[i]));
	endtask

	// random configuration phases with random idle bursts
	task automatic test_random_phases();
		int n;
		while (items_sent < RANDOM_ITEMS) begin
			set_config(op_t'($urandom_range(0, 3)), lw_t'($urandom_range(0, 3)),
				1'($urandom_range(0, 1)), rand_scalar());
			gaps_on = ($urandom_range(0, 3) != 0);
			n = $urandom_range(20, 100);
			repeat (n) send_item(rand_item());
		end
	endtask

	// full rate to the end, with one pause until the pipeline is empty
	task automatic test_full_rate();
		gaps_on = 1'b0;
		set_config(OP_MUL, LW_64, 1'b1, rand_scalar());
		repeat (FULL_RATE_ITEMS / 2) send_item(rand_item());
		wait_results_drained();
		repeat (FULL_RATE_ITEMS / 2) send_item(rand_item());
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		start = 1'b0;
		operands = '0;
		cur_op = OP_ADD;
		cur_lw = LW_8;
		cur_bcast = 1'b0;
		cur_scalar = '0;
		items_sent = 0;
		gaps_on = 1'b1;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_all_ops();
		test_count_edges();
		test_random_phases();
		test_full_rate();

		wait_results_drained();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("packed_lane_add_sub_mul_unit_tb: done, clean");
		end else begin
			$display("packed_lane_add_sub_mul_unit_tb: done, errors");
		end
		$finish;
	end

endmodule
